// ===== hw/rtl/particle_sensor_response_parser_assert.svh =====
// Assertion macros used by the checker module of the sensor response parser.
// Every macro samples on the rising edge of clk.
`ifndef PARTICLE_SENSOR_RESPONSE_PARSER_ASSERT_SVH
`define PARTICLE_SENSOR_RESPONSE_PARSER_ASSERT_SVH

// Checked only while the block is out of reset.
`define PSRP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, during reset as well.
`define PSRP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/psrp_pkg.sv =====
package psrp_pkg;

  // Parser phase codes.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  // Result status codes.
  localparam logic [3:0] ST_ACK      = 4'd0;
  localparam logic [3:0] ST_NACK     = 4'd1;
  localparam logic [3:0] ST_MEASURE  = 4'd2;
  localparam logic [3:0] ST_COEFF    = 4'd3;
  localparam logic [3:0] ST_BADSUM   = 4'd4;
  localparam logic [3:0] ST_UNKNOWN  = 4'd5;
  localparam logic [3:0] ST_TIMEOUT  = 4'd6;
  localparam logic [3:0] ST_OVERFLOW = 4'd7;
  localparam logic [3:0] ST_OTHER    = 4'd8;

  // Frame kinds.
  localparam logic KIND_LEN  = 1'b0;
  localparam logic KIND_AUTO = 1'b1;

  // Header and command bytes.
  localparam logic [7:0] HDR_ACK   = 8'hA5;
  localparam logic [7:0] HDR_NACK  = 8'h96;
  localparam logic [7:0] HDR_LEN   = 8'h40;
  localparam logic [7:0] HDR_AUTO0 = 8'h42;
  localparam logic [7:0] HDR_AUTO1 = 8'h4D;
  localparam logic [7:0] CMD_MEAS  = 8'h04;
  localparam logic [7:0] CMD_COEFF = 8'h10;

  localparam logic [15:0] NO_VALUE = 16'hFFFF;
  localparam logic [7:0]  NO_COEFF = 8'hFF;

  // Autosend frame positions.
  localparam logic [5:0] AUTO_SUM_HI = 6'd30;
  localparam logic [5:0] AUTO_LAST   = 6'd31;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  // Byte compares that the front end works out once per byte.
  typedef struct packed {
    logic is_a5;
    logic is_96;
    logic is_40;
    logic is_42;
    logic is_4d;
    logic is_04;
    logic is_10;
    logic too_long;
  } byte_cls_t;

  // One classified input transaction.
  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    byte_cls_t  cls;
  } item_t;

  // One result.
  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] pm25;
    logic [15:0] pm10;
    logic [7:0]  coeff;
  } result_t;

endpackage

// ===== hw/rtl/particle_sensor_response_parser.sv =====
// Particle sensor response parser.
// The input stream carries one transaction per received serial byte: in_tdata
// is the byte and in_tuser marks a receive timeout event (the byte is then
// ignored). The output stream carries one transaction per completed frame,
// timeout event or rejected header: out_tuser is the status code and out_tdata
// packs the PM2.5 and PM10 readings and the coefficient. Readings that do not
// apply read as all ones.
// A byte accepted by the block is classified and written to a four-entry
// queue; the parser takes it from the queue and writes each result to the
// output register, which drives out_tvalid. The parser handles one byte per
// cycle from the queue, so the block sustains one input transaction per clock
// while results are taken.
// When the receiver holds out_tready low, the result stays in the output
// register and the parser stops taking bytes from the queue until that result
// is taken; the queue then fills and in_tready drops once four transactions
// are waiting in it.
// Reset empties the queue and the output register and returns the parser to
// idle, waiting for the first byte of a frame. There are no configuration
// registers; MAX_FRAME sets the largest length-prefixed frame accepted.
module particle_sensor_response_parser #(
  parameter int unsigned MAX_FRAME = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] func (1 = receive timeout)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] pm25, [31:16] pm10, [39:32] coeff
  output logic [3:0]  out_tuser   // [3:0] status
);
  import psrp_pkg::*;

  item_t push_item;
  item_t q_item;
  logic  push;
  logic  pop;
  logic  q_valid;
  logic  q_full;

  // Front end: takes bytes and works out the header and command compares.
  psrp_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (push),
    .q_item    (push_item)
  );

  // Queue that lets the front end keep accepting while the output stalls.
  psrp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_item    (q_item)
  );

  // Back end: frame state, checksums and the output register.
  psrp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== hw/rtl/psrp_front.sv =====
module psrp_front #(
  parameter int unsigned MAX_FRAME = 32
) (
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  input  logic            in_tuser,
  input  logic            q_full,
  output logic            q_push,
  output psrp_pkg::item_t q_item
);
  import psrp_pkg::*;

  localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME - 3);

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item.func         = in_tuser;
    q_item.rx_byte      = in_tdata;
    q_item.cls.is_a5    = (in_tdata == HDR_ACK);
    q_item.cls.is_96    = (in_tdata == HDR_NACK);
    q_item.cls.is_40    = (in_tdata == HDR_LEN);
    q_item.cls.is_42    = (in_tdata == HDR_AUTO0);
    q_item.cls.is_4d    = (in_tdata == HDR_AUTO1);
    q_item.cls.is_04    = (in_tdata == CMD_MEAS);
    q_item.cls.is_10    = (in_tdata == CMD_COEFF);
    q_item.cls.too_long = (in_tdata > MAX_LEN);
  end

endmodule

// ===== hw/rtl/psrp_queue.sv =====
module psrp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  psrp_pkg::item_t push_item,
  input  logic            pop,
  output logic            q_valid,
  output logic            q_full,
  output psrp_pkg::item_t q_item
);
  import psrp_pkg::*;

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/psrp_back.sv =====
module psrp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  psrp_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [39:0]     out_tdata,
  output logic [3:0]      out_tuser
);
  import psrp_pkg::*;

  logic [1:0]  phase_r,  phase_nxt;
  logic [7:0]  head_r,   head_nxt;
  byte_cls_t   hcls_r,   hcls_nxt;
  logic        kind_r,   kind_nxt;
  logic [5:0]  cnt_r,    cnt_nxt;
  logic [7:0]  len_r,    len_nxt;
  logic [15:0] sum_r,    sum_nxt;
  logic [7:0]  cmd_r,    cmd_nxt;
  logic [7:0]  data_r   [4];
  logic [7:0]  data_nxt [4];
  logic [7:0]  shb_r,    shb_nxt;

  logic        out_valid_r;
  result_t     out_r;

  logic        emit;
  result_t     res;
  logic [7:0]  b;
  logic [8:0]  last_pos;
  logic [7:0]  len_chk;
  logic [15:0] got_sum;

  assign q_pop    = q_valid && (!out_valid_r || out_tready);
  assign b        = q_item.rx_byte;
  assign last_pos = {1'b0, len_r} + 9'd2;
  assign len_chk  = 8'(~sum_r[7:0] + 8'd1);
  assign got_sum  = {shb_r, b};

  always_comb begin
    phase_nxt = phase_r;
    head_nxt  = head_r;
    hcls_nxt  = hcls_r;
    kind_nxt  = kind_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    cmd_nxt   = cmd_r;
    data_nxt  = data_r;
    shb_nxt   = shb_r;
    emit       = 1'b0;
    res.status = ST_TIMEOUT;
    res.pm25   = NO_VALUE;
    res.pm10   = NO_VALUE;
    res.coeff  = NO_COEFF;

    if (q_pop) begin
      if (q_item.func) begin
        emit       = 1'b1;
        res.status = ST_TIMEOUT;
      end else begin
        case (phase_r)
          PH_HEAD: begin
            for (int i = 0; i < 4; i++) begin
              data_nxt[i] = '0;
            end
            sum_nxt = {8'h00, head_r} + {8'h00, b};
            cnt_nxt = 6'd2;
            cmd_nxt = '0;
            shb_nxt = '0;
            if (hcls_r.is_a5 && q_item.cls.is_a5) begin
              emit       = 1'b1;
              res.status = ST_ACK;
            end else if (hcls_r.is_96 && q_item.cls.is_96) begin
              emit       = 1'b1;
              res.status = ST_NACK;
            end else if (hcls_r.is_40) begin
              if (q_item.cls.too_long) begin
                emit       = 1'b1;
                res.status = ST_OVERFLOW;
              end else begin
                len_nxt   = b;
                kind_nxt  = KIND_LEN;
                phase_nxt = PH_BODY;
              end
            end else if (hcls_r.is_42 && q_item.cls.is_4d) begin
              kind_nxt  = KIND_AUTO;
              phase_nxt = PH_BODY;
            end else begin
              emit       = 1'b1;
              res.status = ST_UNKNOWN;
            end
          end
          PH_BODY: begin
            if (kind_r == KIND_LEN) begin
              // Command at position 2, data at positions 3 to 6; the values
              // written by this byte already count for the checksum byte.
              if (cnt_r == 6'd2) begin
                cmd_nxt = b;
              end
              if (cnt_r >= 6'd3 && cnt_r <= 6'd6) begin
                data_nxt[cnt_r[1:0] - 2'd3] = b;
              end
              if ({3'b000, cnt_r} >= last_pos) begin
                emit = 1'b1;
                if (cmd_nxt == CMD_MEAS) begin
                  if (len_chk == b) begin
                    res.status = ST_MEASURE;
                    res.pm25   = {data_nxt[0], data_nxt[1]};
                    res.pm10   = {data_nxt[2], data_nxt[3]};
                  end else begin
                    res.status = ST_BADSUM;
                  end
                end else if (cmd_nxt == CMD_COEFF) begin
                  res.status = ST_COEFF;
                  res.coeff  = data_nxt[0];
                end else begin
                  res.status = ST_OTHER;
                end
              end else begin
                sum_nxt = sum_r + {8'h00, b};
                cnt_nxt = cnt_r + 6'd1;
              end
            end else begin
              // Autosend frame: data at positions 6 to 9, sum over 0 to 29.
              if (cnt_r >= 6'd6 && cnt_r <= 6'd9) begin
                data_nxt[cnt_r[1:0] - 2'd2] = b;
              end
              if (cnt_r < AUTO_SUM_HI) begin
                sum_nxt = sum_r + {8'h00, b};
              end
              if (cnt_r == AUTO_SUM_HI) begin
                shb_nxt = b;
              end
              if (cnt_r >= AUTO_LAST) begin
                emit = 1'b1;
                if (got_sum == sum_r) begin
                  res.status = ST_MEASURE;
                  res.pm25   = {data_r[0], data_r[1]};
                  res.pm10   = {data_r[2], data_r[3]};
                end else begin
                  res.status = ST_BADSUM;
                end
              end else begin
                cnt_nxt = cnt_r + 6'd1;
              end
            end
          end
          default: begin
            head_nxt  = b;
            hcls_nxt  = q_item.cls;
            cnt_nxt   = 6'd1;
            phase_nxt = PH_HEAD;
          end
        endcase
      end
      if (emit) begin
        phase_nxt = PH_IDLE;
        cnt_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      head_r      <= '0;
      hcls_r      <= '0;
      kind_r      <= KIND_LEN;
      cnt_r       <= '0;
      len_r       <= '0;
      sum_r       <= '0;
      cmd_r       <= '0;
      shb_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        data_r[i] <= '0;
      end
    end else begin
      phase_r <= phase_nxt;
      head_r  <= head_nxt;
      hcls_r  <= hcls_nxt;
      kind_r  <= kind_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      cmd_r   <= cmd_nxt;
      shb_r   <= shb_nxt;
      data_r  <= data_nxt;
      if (q_pop && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {out_r.coeff, out_r.pm10, out_r.pm25};

endmodule

// ===== hw/rtl/psrp_checker.sv =====
`include "particle_sensor_response_parser_assert.svh"

module psrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [3:0]  out_tuser
);
  import psrp_pkg::*;

  // A stalled result keeps its contents.
  `PSRP_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // Reset leaves no result pending.
  `PSRP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result pending after reset")

  // Status codes stay within the defined set.
  `PSRP_ASSERT(a_status_range, out_tvalid |-> out_tuser <= ST_OTHER, "undefined status")

  // Readings are all ones unless the frame gave a measurement.
  `PSRP_ASSERT(a_no_reading, out_tvalid && out_tuser != ST_MEASURE |-> out_tdata[31:0] == 32'hFFFF_FFFF, "reading without measurement")

  // The coefficient is all ones unless the frame gave one.
  `PSRP_ASSERT(a_no_coeff, out_tvalid && out_tuser != ST_COEFF |-> out_tdata[39:32] == NO_COEFF, "coefficient without coefficient status")

endmodule

bind particle_sensor_response_parser psrp_checker u_psrp_checker (.*);
